// ===== rtl/core/ica_pkg.sv =====
package ica_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int ROOT_FRAC_BITS = 8;
	localparam int ROOT_WIDTH = (DATA_WIDTH + 1) / 2 + ROOT_FRAC_BITS;
	localparam int NUM_CELLS = (DATA_WIDTH > ROOT_WIDTH) ? DATA_WIDTH : ROOT_WIDTH;
	localparam int RAD_WIDTH = 2 * NUM_CELLS;

	localparam logic [DATA_WIDTH-1:0] HALF = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	typedef enum logic [2:0] {
		CMD_ADD   = 3'd0,
		CMD_SUB   = 3'd1,
		CMD_MUL   = 3'd2,
		CMD_DIV   = 3'd3,
		CMD_POW   = 3'd4,
		CMD_REM   = 3'd5,
		CMD_ROOTS = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_DIV_ZERO = 2'd1,
		ERR_POW_SAT  = 2'd2,
		ERR_NEG_ROOT = 2'd3
	} err_t;

	typedef struct packed {
		logic [RAD_WIDTH-1:0] rad;
		logic [NUM_CELLS-1:0] root;
		logic [NUM_CELLS:0]   rem;
	} root_t;

	typedef struct packed {
		cmd_t                  cmd;
		logic                  a_neg;
		logic                  b_neg;
		logic                  neg_res;
		logic                  div_ok;
		logic                  pw_run;
		logic [DATA_WIDTH-1:0] res_early;
		err_t                  err_early;
		logic [NUM_CELLS-1:0]  dvd;
		logic [DATA_WIDTH-1:0] drem;
		logic [DATA_WIDTH-1:0] dsor;
		root_t                 sa;
		root_t                 sb;
		logic [DATA_WIDTH-1:0] base;
		logic [DATA_WIDTH-1:0] acc;
		logic [NUM_CELLS-1:0]  expo;
		logic                  big;
		logic                  ovf;
	} cell_t;

endpackage

// ===== rtl/core/ica_prep.sv =====
module ica_prep (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [2:0]                     cmd,
	input  logic [ica_pkg::DATA_WIDTH-1:0] operand_a,
	input  logic [ica_pkg::DATA_WIDTH-1:0] operand_b,
	output logic                           valid_s1,
	output ica_pkg::cell_t                 data_s1
);
	import ica_pkg::*;

	localparam int DW = DATA_WIDTH;

	cell_t d;
	logic [DW-1:0] ma;
	logic [DW-1:0] mb;
	logic [DW-1:0] prod;
	logic a_neg;
	logic b_neg;
	logic unit_res;

	always_comb begin
		a_neg = operand_a[DW-1];
		b_neg = operand_b[DW-1];
		ma = a_neg ? (~operand_a + 1'b1) : operand_a;
		mb = b_neg ? (~operand_b + 1'b1) : operand_b;
		prod = operand_a * operand_b;
		d = '0;
		d.cmd = cmd_t'(cmd);
		d.a_neg = a_neg;
		d.b_neg = b_neg;
		d.neg_res = a_neg & operand_b[0];
		d.err_early = ERR_NONE;
		d.dvd = NUM_CELLS'(ma);
		d.dsor = mb;
		d.div_ok = (operand_b != '0);
		d.sa.rad = a_neg ? '0 : (RAD_WIDTH'(operand_a) << (2 * ROOT_FRAC_BITS));
		d.sb.rad = b_neg ? '0 : (RAD_WIDTH'(operand_b) << (2 * ROOT_FRAC_BITS));
		d.base = ma;
		d.acc = DW'(1);
		d.expo = NUM_CELLS'(operand_b);
		unit_res = (ma == DW'(1));
		unique case (d.cmd)
			CMD_ADD: d.res_early = operand_a + operand_b;
			CMD_SUB: d.res_early = operand_a - operand_b;
			CMD_MUL: d.res_early = prod;
			CMD_DIV, CMD_REM: begin
				if (!d.div_ok) d.err_early = ERR_DIV_ZERO;
			end
			CMD_POW: begin
				if (b_neg) begin
					if (ma == '0) begin
						d.res_early = MAX_POS;
						d.err_early = ERR_POW_SAT;
					end else if (unit_res) begin
						d.res_early = d.neg_res ? '1 : DW'(1);
					end
				end else if (operand_b == '0) begin
					d.res_early = DW'(1);
				end else if (ma == '0) begin
					d.res_early = '0;
				end else if (unit_res) begin
					d.res_early = d.neg_res ? '1 : DW'(1);
				end else begin
					d.pw_run = 1'b1;
				end
			end
			CMD_ROOTS: begin
				if (a_neg || b_neg) d.err_early = ERR_NEG_ROOT;
			end
			default: d.res_early = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= d;
		end
	end

endmodule

// ===== rtl/core/ica_cell.sv =====
module ica_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           prev_valid,
	input  ica_pkg::cell_t prev_data,
	output logic           valid_q,
	output ica_pkg::cell_t data_q
);
	import ica_pkg::*;

	localparam int DW = DATA_WIDTH;

	function automatic root_t root_step(root_t s);
		root_t o;
		logic [NUM_CELLS+2:0] r;
		logic [NUM_CELLS+1:0] t;
		r = {s.rem, s.rad[RAD_WIDTH-1 -: 2]};
		t = {s.root, 2'b01};
		o.rad = s.rad << 2;
		if (r >= {1'b0, t}) begin
			r = r - {1'b0, t};
			o.root = {s.root[NUM_CELLS-2:0], 1'b1};
		end else begin
			o.root = {s.root[NUM_CELLS-2:0], 1'b0};
		end
		o.rem = r[NUM_CELLS:0];
		return o;
	endfunction

	cell_t d;
	logic [DW:0] dr;
	logic qbit;
	logic [DW-1:0] limit;
	logic [2*DW-1:0] pr;
	logic [2*DW-1:0] pb;

	always_comb begin
		d = prev_data;
		dr = {prev_data.drem, prev_data.dvd[NUM_CELLS-1]};
		qbit = 1'b0;
		if (dr >= {1'b0, prev_data.dsor}) begin
			dr = dr - {1'b0, prev_data.dsor};
			qbit = 1'b1;
		end
		d.drem = dr[DW-1:0];
		d.dvd = {prev_data.dvd[NUM_CELLS-2:0], qbit};

		d.sa = root_step(prev_data.sa);
		d.sb = root_step(prev_data.sb);

		limit = prev_data.neg_res ? HALF : MAX_POS;
		pr = {{DW{1'b0}}, prev_data.acc} * {{DW{1'b0}}, prev_data.base};
		pb = {{DW{1'b0}}, prev_data.base} * {{DW{1'b0}}, prev_data.base};
		if (prev_data.expo[0] && !prev_data.ovf) begin
			if (prev_data.big || (pr > {{DW{1'b0}}, limit})) begin
				d.ovf = 1'b1;
			end else begin
				d.acc = pr[DW-1:0];
			end
		end
		if (!prev_data.big) begin
			if (pb > {{DW{1'b0}}, limit}) begin
				d.big = 1'b1;
			end else begin
				d.base = pb[DW-1:0];
			end
		end
		d.expo = prev_data.expo >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= d;
		end
	end

endmodule

// ===== rtl/core/ica_finish.sv =====
module ica_finish (
	input  ica_pkg::cell_t                 data,
	output logic [ica_pkg::DATA_WIDTH-1:0] res,
	output logic [ica_pkg::ROOT_WIDTH-1:0] ra,
	output logic [ica_pkg::ROOT_WIDTH-1:0] rb,
	output logic [1:0]                     err
);
	import ica_pkg::*;

	localparam int DW = DATA_WIDTH;

	logic [DW-1:0] q;

	always_comb begin
		q = data.dvd[DW-1:0];
		res = data.res_early;
		ra = '0;
		rb = '0;
		err = data.err_early;
		unique case (data.cmd)
			CMD_DIV: begin
				if (data.div_ok) res = (data.a_neg ^ data.b_neg) ? (~q + 1'b1) : q;
			end
			CMD_REM: begin
				if (data.div_ok) res = data.a_neg ? (~data.drem + 1'b1) : data.drem;
			end
			CMD_POW: begin
				if (data.pw_run) begin
					if (data.ovf) begin
						res = data.neg_res ? HALF : MAX_POS;
						err = ERR_POW_SAT;
					end else begin
						res = data.neg_res ? (~data.acc + 1'b1) : data.acc;
					end
				end
			end
			CMD_ROOTS: begin
				res = '0;
				ra = data.sa.root[ROOT_WIDTH-1:0];
				rb = data.sb.root[ROOT_WIDTH-1:0];
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/integer_calculator_alu.sv =====
// Channel | Handshake           | Payload
// in      | in_valid, in_stall  | cmd, operand_a, operand_b
// out     | out_valid, out_stall| result_value, root_a, root_b, error_code
//
// There are NUM_CELLS + 2 register stages (34): the input stage, the cells and the output register.
// A transaction passes from the input stage through each cell in turn to the output register, and
// each cell does one divide, root and power step. One transaction enters per cycle while in_stall
// is low; any empty stage lets the row close up under a stall.
// Reset clears only the valid bits of the stages and the output register.
module integer_calculator_alu (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     cmd,
	input  logic [ica_pkg::DATA_WIDTH-1:0] operand_a,
	input  logic [ica_pkg::DATA_WIDTH-1:0] operand_b,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ica_pkg::DATA_WIDTH-1:0] result_value,
	output logic [ica_pkg::ROOT_WIDTH-1:0] root_a,
	output logic [ica_pkg::ROOT_WIDTH-1:0] root_b,
	output logic [1:0]                     error_code
);
	import ica_pkg::*;

	cell_t cdata [NUM_CELLS+1];
	logic  cvalid [NUM_CELLS+1];
	logic  cen [NUM_CELLS+1];
	logic  en_out;

	logic [DATA_WIDTH-1:0] fin_res;
	logic [ROOT_WIDTH-1:0] fin_ra;
	logic [ROOT_WIDTH-1:0] fin_rb;
	logic [1:0]            fin_err;

	assign en_out = !out_valid || !out_stall;
	assign cen[NUM_CELLS] = !cvalid[NUM_CELLS] || en_out;

	genvar k;
	generate
		for (k = 0; k < NUM_CELLS; k++) begin : g_en
			assign cen[k] = !cvalid[k] || cen[k+1];
		end
	endgenerate

	assign in_stall = !cen[0];

	ica_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (cen[0]),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.valid_s1  (cvalid[0]),
		.data_s1   (cdata[0])
	);

	generate
		for (k = 0; k < NUM_CELLS; k++) begin : g_cell
			ica_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.en         (cen[k+1]),
				.prev_valid (cvalid[k]),
				.prev_data  (cdata[k]),
				.valid_q    (cvalid[k+1]),
				.data_q     (cdata[k+1])
			);
		end
	endgenerate

	ica_finish u_finish (
		.data (cdata[NUM_CELLS]),
		.res  (fin_res),
		.ra   (fin_ra),
		.rb   (fin_rb),
		.err  (fin_err)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_out) begin
			out_valid <= cvalid[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			result_value <= fin_res;
			root_a <= fin_ra;
			root_b <= fin_rb;
			error_code <= fin_err;
		end
	end

endmodule

// ===== rtl/core/ica_checker.sv =====
module ica_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [ica_pkg::DATA_WIDTH-1:0] result_value,
	input logic [ica_pkg::ROOT_WIDTH-1:0] root_a,
	input logic [ica_pkg::ROOT_WIDTH-1:0] root_b,
	input logic [1:0]                     error_code
);
	import ica_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(error_code))
		else $error("Stalled output transaction changed.");

	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code == ERR_DIV_ZERO) |-> result_value == '0)
		else $error("Divide by zero gave a nonzero result.");

	a_neg_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code == ERR_NEG_ROOT) |->
			(result_value == '0) && ((root_a == '0) || (root_b == '0)))
		else $error("Negative root transaction carries bad fields.");

	a_pow_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code == ERR_POW_SAT) |->
			(result_value == MAX_POS) || (result_value == HALF))
		else $error("Saturated power is not an extreme value.");

endmodule

bind integer_calculator_alu ica_checker u_ica_checker (.*);

// ===== tb/integer_calculator_alu_checker.sv =====
`timescale 1ns / 100ps

module integer_calculator_alu_checker
	import ica_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [2:0]            cmd,
	input  logic [DATA_WIDTH-1:0] operand_a,
	input  logic [DATA_WIDTH-1:0] operand_b,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [DATA_WIDTH-1:0] result_value,
	input  logic [ROOT_WIDTH-1:0] root_a,
	input  logic [ROOT_WIDTH-1:0] root_b,
	input  logic [1:0]            error_code,
	output int                    errors,
	output int                    pending
);

	typedef struct {
		logic [DATA_WIDTH-1:0] value;
		logic [ROOT_WIDTH-1:0] ra;
		logic [ROOT_WIDTH-1:0] rb;
		err_t                  err;
	} alu_result_t;

	alu_result_t expected_results[$];

	function automatic logic [ROOT_WIDTH-1:0] fixed_sqrt(input logic [DATA_WIDTH-1:0] x);
		logic [63:0] radicand;
		logic [63:0] trial;
		logic [63:0] root;
		radicand = 64'(x) << (2 * ROOT_FRAC_BITS);
		root = 0;
		for (int i = ROOT_WIDTH - 1; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= radicand) begin
				root = trial;
			end
		end
		return root[ROOT_WIDTH-1:0];
	endfunction

	function automatic alu_result_t compute_alu(input logic [2:0] op,
			input logic [DATA_WIDTH-1:0] a, input logic [DATA_WIDTH-1:0] b);
		alu_result_t r;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] acc;
		logic [63:0] limit;
		logic        a_neg;
		logic        b_neg;
		logic        neg_res;
		a_neg = a[DATA_WIDTH-1];
		b_neg = b[DATA_WIDTH-1];
		ma = a_neg ? (64'd1 << DATA_WIDTH) - 64'(a) : 64'(a);
		mb = b_neg ? (64'd1 << DATA_WIDTH) - 64'(b) : 64'(b);
		r.value = '0;
		r.ra = '0;
		r.rb = '0;
		r.err = ERR_NONE;
		case (op)
			CMD_ADD: r.value = a + b;
			CMD_SUB: r.value = a - b;
			CMD_MUL: r.value = a * b;
			CMD_DIV, CMD_REM: begin
				if (b == 0) begin
					r.err = ERR_DIV_ZERO;
				end else if (op == CMD_DIV) begin
					acc = ma / mb;
					r.value = (a_neg != b_neg) ? -acc[DATA_WIDTH-1:0] : acc[DATA_WIDTH-1:0];
				end else begin
					acc = ma % mb;
					r.value = a_neg ? -acc[DATA_WIDTH-1:0] : acc[DATA_WIDTH-1:0];
				end
			end
			CMD_POW: begin
				neg_res = a_neg && b[0];
				if (b_neg) begin
					if (ma == 0) begin
						r.value = MAX_POS;
						r.err = ERR_POW_SAT;
					end else if (ma == 1) begin
						r.value = neg_res ? '1 : 1;
					end
				end else if (b == 0) begin
					r.value = 1;
				end else if (ma == 1) begin
					r.value = neg_res ? '1 : 1;
				end else if (ma != 0) begin
					limit = neg_res ? 64'(HALF) : 64'(MAX_POS);
					acc = 1;
					for (longint unsigned n = 0; n < 64'(b); n++) begin
						if (acc > limit / ma) begin
							r.err = ERR_POW_SAT;
							break;
						end
						acc = acc * ma;
					end
					if (r.err == ERR_POW_SAT) begin
						r.value = neg_res ? HALF : MAX_POS;
					end else begin
						r.value = neg_res ? -acc[DATA_WIDTH-1:0] : acc[DATA_WIDTH-1:0];
					end
				end
			end
			CMD_ROOTS: begin
				if (a_neg) r.err = ERR_NEG_ROOT;
				else r.ra = fixed_sqrt(a);
				if (b_neg) r.err = ERR_NEG_ROOT;
				else r.rb = fixed_sqrt(b);
			end
			default: ;
		endcase
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		alu_result_t want;
		int          bad;
		bad = 0;
		if (!arst_n) begin
			expected_results.delete();
			errors <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("Result transaction arrived with no transaction outstanding.");
					bad++;
				end else begin
					want = expected_results.pop_front();
					if (result_value !== want.value) begin
						$error("result_value: expected %h, actual %h", want.value, result_value);
						bad++;
					end
					if (root_a !== want.ra) begin
						$error("root_a: expected %h, actual %h", want.ra, root_a);
						bad++;
					end
					if (root_b !== want.rb) begin
						$error("root_b: expected %h, actual %h", want.rb, root_b);
						bad++;
					end
					if (error_code !== want.err) begin
						$error("error_code: expected %0d, actual %0d", want.err, error_code);
						bad++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				expected_results.push_back(compute_alu(cmd, operand_a, operand_b));
			end
			errors <= errors + bad;
		end
	end

endmodule

// ===== tb/integer_calculator_alu_tb.sv =====
`timescale 1ns / 100ps

module integer_calculator_alu_tb;
	import ica_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 1200;
	localparam int DRAIN_CYCLES = 80;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [2:0]            cmd = CMD_ADD;
	logic [DATA_WIDTH-1:0] operand_a = '0;
	logic [DATA_WIDTH-1:0] operand_b = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [DATA_WIDTH-1:0] result_value;
	logic [ROOT_WIDTH-1:0] root_a;
	logic [ROOT_WIDTH-1:0] root_b;
	logic [1:0]            error_code;
	int                    errors;
	int                    pending;
	int                    idle_cycles = 0;
	logic                  fast_phase = 1'b0;

	always #2 clk = ~clk;

	integer_calculator_alu DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .root_a(root_a), .root_b(root_b),
		.error_code(error_code)
	);

	integer_calculator_alu_checker checker_inst (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .root_a(root_a), .root_b(root_b),
		.error_code(error_code),
		.errors(errors), .pending(pending)
	);

	function automatic int random_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (fast_phase || pick < 60) return 0;
		if (pick < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [DATA_WIDTH-1:0] random_operand();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 20);
			1: return -$urandom_range(0, 20);
			2: return $urandom_range(0, 1) ? HALF : MAX_POS;
			3: return $urandom_range(0, 1) ? '1 : 1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input logic [2:0] op, input logic [DATA_WIDTH-1:0] a,
			input logic [DATA_WIDTH-1:0] b);
		int gap;
		in_valid <= 1'b1;
		cmd <= op;
		operand_a <= a;
		operand_b <= b;
		do @(posedge clk); while (in_stall);
		gap = random_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("integer_calculator_alu_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int pick;
		wait (arst_n);
		repeat (200) @(posedge clk);
		out_stall <= 1'b1;
		repeat (400) @(posedge clk);
		out_stall <= 1'b0;
		forever begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end else if (pick < 95) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(10, 50)) @(posedge clk);
			end
		end
	end

	initial begin
		logic [2:0]            op;
		logic [DATA_WIDTH-1:0] a;
		logic [DATA_WIDTH-1:0] b;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(CMD_ADD, MAX_POS, 1);
		send_item(CMD_SUB, HALF, 1);
		send_item(CMD_MUL, HALF, '1);
		send_item(CMD_MUL, MAX_POS, MAX_POS);
		send_item(CMD_DIV, HALF, '1);
		send_item(CMD_DIV, -7, 2);
		send_item(CMD_DIV, 5, 0);
		send_item(CMD_REM, -7, 2);
		send_item(CMD_REM, HALF, '1);
		send_item(CMD_REM, 9, 0);
		send_item(CMD_POW, 0, -3);
		send_item(CMD_POW, 1, -5);
		send_item(CMD_POW, '1, -5);
		send_item(CMD_POW, 2, -1);
		send_item(CMD_POW, 0, 0);
		send_item(CMD_POW, 3, 40);
		send_item(CMD_POW, -3, 41);
		send_item(CMD_POW, -2, 31);
		send_item(CMD_POW, 2, 31);
		send_item(CMD_ROOTS, MAX_POS, 0);
		send_item(CMD_ROOTS, HALF, 2);
		send_item(CMD_ROOTS, 3, '1);
		send_item(3'd7, MAX_POS, HALF);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 200 == 0) fast_phase <= ($urandom_range(0, 2) == 0);
			op = $urandom_range(0, 7);
			a = random_operand();
			b = random_operand();
			if (op == CMD_POW && $urandom_range(0, 3) != 0) begin
				a = $urandom_range(0, 1) ? $urandom_range(0, 12) : -$urandom_range(0, 12);
				b = $urandom_range(0, 40) - 3;
			end
			if ((op == CMD_DIV || op == CMD_REM) && $urandom_range(0, 9) == 0) b = '0;
			send_item(op, a, b);
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("integer_calculator_alu_tb: PASS");
		end else begin
			$display("integer_calculator_alu_tb: FAIL");
		end
		$finish;
	end

endmodule
